FILE: design/lkvc_pkg.sv
// Shared types and constants for the LRU key/value cache.
package lkvc_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    typedef struct packed {
        logic                    req_type;
        logic signed [KEY_W-1:0] lookup_key;
        logic signed [VAL_W-1:0] write_value;
    } req_t;

    typedef struct packed {
        logic                    found;
        logic signed [VAL_W-1:0] read_value;
        logic                    evicted;
        logic signed [KEY_W-1:0] evicted_key;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic issue;
        logic prep;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic last_addr;
        logic out_free;
    } status_t;

endpackage

FILE: design/lkvc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lkvc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

FILE: design/lkvc_ctrl.sv
// Request sequencer: accept, scan, decide, commit.
module lkvc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  lkvc_pkg::status_t status,
    output lkvc_pkg::cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_DRAIN  = 5'b00100,
        ST_PREP   = 5'b01000,
        ST_COMMIT = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.issue = 1'b1;
                if (status.last_addr)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_commit_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> status.out_free)
        else $error("commit while result register occupied");
    a_scan_follows_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.issue)
        else $error("scan did not start after request transfer");
    a_prep_before_commit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.prep |=> (state_reg == ST_COMMIT))
        else $error("decision step not followed by commit");
`endif

endmodule

FILE: design/lkvc_datapath.sv
// Key/value storage, recency ranks, scan compare and result register.
module lkvc_datapath #(
    parameter int ENTRIES = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [lkvc_pkg::CAP_W-1:0]   cfg_wr_data,
    input  lkvc_pkg::req_t               req,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output lkvc_pkg::rsp_t               rsp,
    input  lkvc_pkg::cmd_t               cmd,
    output lkvc_pkg::status_t            status
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W = $clog2(ENTRIES + 1);

    lkvc_pkg::req_t                req_reg;
    logic [IDX_W-1:0]              scan_addr_reg;
    logic [IDX_W-1:0]              cmp_idx_reg;
    logic                          cmp_valid_reg;
    logic [lkvc_pkg::KEY_W-1:0]    key_rd;
    logic [lkvc_pkg::VAL_W-1:0]    val_rd;

    logic                          hit_found_reg;
    logic [IDX_W-1:0]              hit_idx_reg;
    logic [lkvc_pkg::VAL_W-1:0]    hit_value_reg;
    logic                          lru_found_reg;
    logic [IDX_W-1:0]              lru_idx_reg;
    logic [lkvc_pkg::KEY_W-1:0]    lru_key_reg;
    logic                          inv_found_reg;
    logic [IDX_W-1:0]              inv_idx_reg;

    logic [ENTRIES-1:0]            valid_reg;
    logic [IDX_W-1:0]              rank_reg [ENTRIES];
    logic [OCC_W-1:0]              occ_reg;
    logic [lkvc_pkg::CAP_W-1:0]    cap_reg;

    logic [IDX_W-1:0]              old_rank_reg;
    logic                          evict_reg;
    logic                          insert_reg;
    logic [IDX_W-1:0]              slot_reg;

    lkvc_pkg::rsp_t                rsp_reg;
    logic                          rsp_valid_reg;

    logic [ENTRIES-1:0]            lru_vec;
    logic [OCC_W-1:0]              occ_m1;
    logic [OCC_W-1:0]              eff_cap;
    logic [IDX_W-1:0]              old_rank;
    logic                          is_put;
    logic                          evict_now;
    logic                          insert_now;
    logic [IDX_W-1:0]              slot_now;
    logic                          key_match;
    logic                          key_we;
    logic                          val_we;
    logic [IDX_W-1:0]              val_waddr;

    lkvc_ram #(
        .WIDTH (lkvc_pkg::KEY_W),
        .DEPTH (ENTRIES)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (key_we),
        .wr_addr (slot_reg),
        .wr_data (req_reg.lookup_key),
        .rd_en   (cmd.issue),
        .rd_addr (scan_addr_reg),
        .rd_data (key_rd)
    );

    lkvc_ram #(
        .WIDTH (lkvc_pkg::VAL_W),
        .DEPTH (ENTRIES)
    ) u_val_ram (
        .clk     (clk),
        .wr_en   (val_we),
        .wr_addr (val_waddr),
        .wr_data (req_reg.write_value),
        .rd_en   (cmd.issue),
        .rd_addr (scan_addr_reg),
        .rd_data (val_rd)
    );

    assign is_put    = (req_reg.req_type == lkvc_pkg::REQ_PUT);
    assign occ_m1    = occ_reg - 1'b1;
    assign key_match = cmp_valid_reg && valid_reg[cmp_idx_reg]
                       && (key_rd == $unsigned(req_reg.lookup_key));
    assign key_we    = cmd.commit && insert_reg;
    assign val_we    = cmd.commit && (insert_reg || (hit_found_reg && is_put));
    assign val_waddr = hit_found_reg ? hit_idx_reg : slot_reg;

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            lru_vec[i] = valid_reg[i] && (OCC_W'(rank_reg[i]) == occ_m1);
        end
    end

    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = OCC_W'(1);
        end
        else if (int'(cap_reg) > ENTRIES)
        begin
            eff_cap = OCC_W'(ENTRIES);
        end
        else
        begin
            eff_cap = OCC_W'(cap_reg);
        end
    end

    always_comb
    begin
        old_rank = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (IDX_W'(i) == hit_idx_reg)
            begin
                old_rank = old_rank | rank_reg[i];
            end
        end
    end

    always_comb
    begin
        evict_now  = is_put && !hit_found_reg && (occ_reg != '0)
                     && (occ_reg >= eff_cap) && lru_found_reg;
        insert_now = is_put && !hit_found_reg && (evict_now || inv_found_reg);
        if (evict_now && !(inv_found_reg && (inv_idx_reg < lru_idx_reg)))
        begin
            slot_now = lru_idx_reg;
        end
        else
        begin
            slot_now = inv_idx_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        cmp_idx_reg <= scan_addr_reg;
        if (cmd.prep)
        begin
            old_rank_reg <= old_rank;
            slot_reg     <= slot_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_addr_reg <= '0;
            cmp_valid_reg <= 1'b0;
            hit_found_reg <= 1'b0;
            hit_idx_reg   <= '0;
            hit_value_reg <= '0;
            lru_found_reg <= 1'b0;
            lru_idx_reg   <= '0;
            lru_key_reg   <= '0;
            inv_found_reg <= 1'b0;
            inv_idx_reg   <= '0;
            evict_reg     <= 1'b0;
            insert_reg    <= 1'b0;
        end
        else
        begin
            cmp_valid_reg <= cmd.issue;
            if (cmd.load)
            begin
                scan_addr_reg <= '0;
                hit_found_reg <= 1'b0;
                lru_found_reg <= 1'b0;
                inv_found_reg <= 1'b0;
            end
            else
            begin
                if (cmd.issue)
                begin
                    scan_addr_reg <= scan_addr_reg + 1'b1;
                end
                if (key_match && !hit_found_reg)
                begin
                    hit_found_reg <= 1'b1;
                    hit_idx_reg   <= cmp_idx_reg;
                    hit_value_reg <= val_rd;
                end
                if (cmp_valid_reg && lru_vec[cmp_idx_reg])
                begin
                    lru_found_reg <= 1'b1;
                    lru_idx_reg   <= cmp_idx_reg;
                    lru_key_reg   <= key_rd;
                end
                if (cmp_valid_reg && !valid_reg[cmp_idx_reg] && !inv_found_reg)
                begin
                    inv_found_reg <= 1'b1;
                    inv_idx_reg   <= cmp_idx_reg;
                end
            end
            if (cmd.prep)
            begin
                evict_reg  <= evict_now;
                insert_reg <= insert_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            occ_reg   <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else if (cmd.commit)
        begin
            if (hit_found_reg)
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (IDX_W'(i) == hit_idx_reg)
                    begin
                        rank_reg[i] <= '0;
                    end
                    else if (valid_reg[i] && (rank_reg[i] < old_rank_reg))
                    begin
                        rank_reg[i] <= rank_reg[i] + 1'b1;
                    end
                end
            end
            else if (insert_reg)
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (IDX_W'(i) == slot_reg)
                    begin
                        rank_reg[i]  <= '0;
                        valid_reg[i] <= 1'b1;
                    end
                    else if (evict_reg && (IDX_W'(i) == lru_idx_reg))
                    begin
                        rank_reg[i]  <= '0;
                        valid_reg[i] <= 1'b0;
                    end
                    else if (valid_reg[i])
                    begin
                        rank_reg[i] <= rank_reg[i] + 1'b1;
                    end
                end
                if (!evict_reg)
                begin
                    occ_reg <= occ_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= lkvc_pkg::CAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            cap_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            rsp_reg.found       <= hit_found_reg;
            rsp_reg.read_value  <= (hit_found_reg && !is_put) ? hit_value_reg : '0;
            rsp_reg.evicted     <= evict_reg;
            rsp_reg.evicted_key <= evict_reg ? lru_key_reg : '0;
        end
    end

    assign rsp              = rsp_reg;
    assign rsp_valid        = rsp_valid_reg;
    assign status.last_addr = (scan_addr_reg == IDX_W'(ENTRIES - 1));
    assign status.out_free  = !rsp_valid_reg || rsp_ready;

`ifndef NO_ASSERTIONS
    a_occ_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(ENTRIES))
        else $error("occupancy above entry count");
    a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(occ_reg))
        else $error("occupancy disagrees with valid marks");
    a_occ_stable_on_swap: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && (hit_found_reg || evict_reg)) |=> $stable(occ_reg))
        else $error("occupancy changed on hit or evicting insert");
    a_single_lru: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(lru_vec))
        else $error("more than one least recent entry");
`endif

endmodule

FILE: design/lru_key_value_cache_unit.sv
// Top level of the fully associative LRU key/value cache.
// A request is taken, then the key RAM is read one entry per cycle and
// each key compared across all ENTRIES entries, then the last compare
// drains, then hit, victim and free slot are picked, and then ranks,
// valid marks and the RAMs are updated. The result sits in an output
// register, so a request is taken while a previous result still waits;
// the commit step holds only while that register is occupied and not being read.
// Recency is kept as a rank per entry (0 most recent). A capacity of zero
// acts as one and a capacity above ENTRIES acts as ENTRIES.
module lru_key_value_cache_unit #(
    parameter int ENTRIES = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [lkvc_pkg::CAP_W-1:0] cfg_wr_data,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  lkvc_pkg::req_t             req,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output lkvc_pkg::rsp_t             rsp
);

    lkvc_pkg::cmd_t    cmd;
    lkvc_pkg::status_t status;

    lkvc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    lkvc_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .cmd         (cmd),
        .status      (status)
    );

endmodule
